// File: hdl/hpm_pkg.sv
// Shared types, constants and the bit-count function of the Hamming pair matcher.
package hpm_pkg;

    localparam int KEY_MAX     = 128;
    localparam int WGT_W       = 8;
    localparam int QIDX_W      = 16;
    localparam int RIDX_W      = 6;
    localparam int THR_W       = 9;
    localparam int CFG_W       = 8;
    localparam int IN_TDATA_W  = 176;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [1:0] {
        REQ_THR   = 2'd0,
        REQ_STORE = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_WEIGHT = 2'd2
    } t_status;

    typedef enum logic {
        CFG_SAME_SET   = 1'b0,
        CFG_MAX_WEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_WALK,
        BS_DRAIN
    } t_bstate;

    // Classified request handed from the front to the back
    typedef struct packed {
        t_req                     kind;
        t_status                  status;
        logic [KEY_MAX-1:0]       key;
        logic [WGT_W-1:0]         weight;
        logic [QIDX_W-1:0]        qidx;
        logic [WGT_W-1:0]         row;
        logic [WGT_W-1:0]         col;
        logic signed [THR_W-1:0]  tval;
    } t_cmd;

    typedef struct packed {
        logic                     pair_valid;
        logic [RIDX_W-1:0]        ref_index;
        logic [QIDX_W-1:0]        pair_query_index;
        logic [WGT_W-1:0]         distance;
        logic                     last;
        t_status                  status;
    } t_res;

    // Seven-level adder tree over the key bits
    function automatic logic [WGT_W-1:0] hpm_popcnt(input logic [KEY_MAX-1:0] v);
        logic [WGT_W-1:0] s [KEY_MAX];
        for (int i = 0; i < KEY_MAX; i++) begin
            s[i] = WGT_W'(v[i]);
        end
        for (int l = 0; l < 7; l++) begin
            for (int j = 0; j < (64 >> l); j++) begin
                s[j] = s[2*j] + s[2*j+1];
            end
        end
        return s[0];
    endfunction

endpackage

// File: hdl/hpm_fifo.sv
// Small synchronous FIFO used for the request queue and the result queue.
module hpm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_data,
    input  logic                         i_pop,
    output logic [WIDTH-1:0]             o_data,
    output logic                         o_empty,
    output logic                         o_full,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_push, w_pop;

    assign w_push  = i_push && (r_count != CW'(DEPTH));
    assign w_pop   = i_pop && (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_count = r_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: hdl/hpm_front.sv
// Front end: takes request words, counts key weight and checks limits.
module hpm_front #(
    parameter int KEY_BITS = 128
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  hpm_pkg::t_req                     i_req,
    input  logic [63:0]                       i_key_low,
    input  logic [63:0]                       i_key_high,
    input  logic [hpm_pkg::QIDX_W-1:0]        i_qidx,
    input  logic [hpm_pkg::WGT_W-1:0]         i_row,
    input  logic [hpm_pkg::WGT_W-1:0]         i_col,
    input  logic signed [hpm_pkg::THR_W-1:0]  i_tval,
    input  logic [hpm_pkg::WGT_W-1:0]         i_lim,
    input  logic                              i_enable,
    input  logic                              i_q_full,
    output logic                              o_push,
    output hpm_pkg::t_cmd                     o_cmd
);
    import hpm_pkg::*;

    localparam logic [KEY_MAX-1:0] KEY_MASK = (KEY_MAX'(1) << KEY_BITS) - KEY_MAX'(1);

    logic                     r_valid;
    t_req                     r_req;
    logic [KEY_MAX-1:0]       r_key;
    logic [QIDX_W-1:0]        r_qidx;
    logic [WGT_W-1:0]         r_row;
    logic [WGT_W-1:0]         r_col;
    logic signed [THR_W-1:0]  r_tval;
    logic                     w_accept;
    logic [WGT_W-1:0]         w_weight;

    assign o_ready  = i_enable && (!r_valid || !i_q_full);
    assign w_accept = i_valid && o_ready;
    assign o_push   = r_valid && !i_q_full;
    assign w_weight = hpm_popcnt(r_key);

    always_comb begin
        o_cmd        = '0;
        o_cmd.kind   = r_req;
        o_cmd.key    = r_key;
        o_cmd.weight = w_weight;
        o_cmd.qidx   = r_qidx;
        o_cmd.row    = r_row;
        o_cmd.col    = r_col;
        o_cmd.tval   = r_tval;
        o_cmd.status = STAT_OK;
        case (r_req)
            REQ_THR: begin
                if (r_row > i_lim || r_col > i_lim) begin
                    o_cmd.status = STAT_WEIGHT;
                end
            end
            REQ_STORE, REQ_QUERY: begin
                if (w_weight > i_lim) begin
                    o_cmd.status = STAT_WEIGHT;
                end
            end
            default: begin
                o_cmd.status = STAT_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req  <= i_req;
            r_key  <= {i_key_high, i_key_low} & KEY_MASK;
            r_qidx <= i_qidx;
            r_row  <= i_row;
            r_col  <= i_col;
            r_tval <= i_tval;
        end
    end

endmodule

// File: hdl/hpm_back.sv
// Back end: owns the key store and threshold table, runs stores and query walks.
module hpm_back #(
    parameter int KEY_BITS  = 128,
    parameter int REF_DEPTH = 64,
    parameter int OUT_DEPTH = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cmd_valid,
    input  hpm_pkg::t_cmd                         i_cmd,
    output logic                                  o_cmd_pop,
    input  logic [hpm_pkg::WGT_W-1:0]             i_lim,
    input  logic                                  i_same_set,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]        i_out_count,
    output logic                                  o_res_push,
    output hpm_pkg::t_res                         o_res,
    output logic                                  o_ready
);
    import hpm_pkg::*;

    localparam int TDIM   = KEY_BITS + 1;
    localparam int TDEPTH = TDIM * TDIM;
    localparam int TA_W   = $clog2(TDEPTH);
    localparam int IDX_W  = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
    localparam int CNT_W  = $clog2(REF_DEPTH + 1);
    localparam int OC_W   = $clog2(OUT_DEPTH + 1);

    // Storage
    logic [KEY_BITS-1:0]      m_ref_key [REF_DEPTH];
    logic [WGT_W-1:0]         m_ref_w   [REF_DEPTH];
    logic signed [THR_W-1:0]  m_thr     [TDEPTH];

    t_bstate                  r_state, n_state;
    logic [TA_W-1:0]          r_clr_addr, n_clr_addr;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [IDX_W-1:0]         r_idx, n_idx;
    logic [KEY_BITS-1:0]      r_qkey;
    logic [WGT_W-1:0]         r_qw;
    logic [QIDX_W-1:0]        r_qidx;

    // Walk pipeline: issue -> ref read -> threshold read + distance -> test
    logic                     r_s1_valid;
    logic [IDX_W-1:0]         r_s1_idx;
    logic [KEY_BITS-1:0]      r_rd_key;
    logic [WGT_W-1:0]         r_rd_w;
    logic                     r_s2_valid;
    logic [IDX_W-1:0]         r_s2_idx;
    logic [WGT_W-1:0]         r_s2_rw;
    logic [WGT_W-1:0]         r_s2_dist;
    logic signed [THR_W-1:0]  r_s2_thr;
    logic                     r_hold_v;
    t_res                     r_hold;

    logic                     w_full, w_room3;
    logic                     w_issue, w_latch_q, w_ref_we, w_thr_we;
    logic                     w_fsm_push, w_s2_match, w_s2_push;
    t_res                     w_fsm_res, w_s2_res;
    logic [TA_W-1:0]          w_thr_waddr, w_thr_raddr;

    assign w_full  = (i_out_count == OC_W'(OUT_DEPTH));
    // Up to two walk entries are still in flight when a new one is issued
    assign w_room3 = (32'(OUT_DEPTH) - 32'(i_out_count)) >= 32'd3;
    assign o_ready = (r_state != BS_CLEAR);

    assign w_thr_waddr = TA_W'(32'(i_cmd.row) * TDIM + 32'(i_cmd.col));
    assign w_thr_raddr = TA_W'(32'(r_rd_w) * TDIM + 32'(r_qw));

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_count    = r_count;
        n_idx      = r_idx;
        o_cmd_pop  = 1'b0;
        w_fsm_push = 1'b0;
        w_fsm_res  = '0;
        w_ref_we   = 1'b0;
        w_thr_we   = 1'b0;
        w_issue    = 1'b0;
        w_latch_q  = 1'b0;
        case (r_state)
            BS_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == TA_W'(TDEPTH - 1)) begin
                    n_state = BS_IDLE;
                end
            end
            BS_IDLE: begin
                if (i_cmd_valid && !w_full) begin
                    o_cmd_pop       = 1'b1;
                    w_fsm_res.last  = 1'b1;
                    case (i_cmd.kind)
                        REQ_QUERY: begin
                            if (i_cmd.status == STAT_WEIGHT) begin
                                w_fsm_push                 = 1'b1;
                                w_fsm_res.pair_query_index = i_cmd.qidx;
                                w_fsm_res.status           = STAT_WEIGHT;
                            end else begin
                                w_latch_q = 1'b1;
                                n_idx     = '0;
                                n_state   = (r_count == '0) ? BS_DRAIN : BS_WALK;
                            end
                        end
                        REQ_THR: begin
                            w_fsm_push       = 1'b1;
                            w_fsm_res.status = i_cmd.status;
                            w_thr_we         = (i_cmd.status == STAT_OK);
                        end
                        REQ_STORE: begin
                            w_fsm_push = 1'b1;
                            if (i_cmd.status == STAT_WEIGHT) begin
                                w_fsm_res.status = STAT_WEIGHT;
                            end else if (32'(r_count) >= REF_DEPTH) begin
                                w_fsm_res.status = STAT_FULL;
                            end else begin
                                w_ref_we            = 1'b1;
                                w_fsm_res.ref_index = RIDX_W'(r_count);
                                n_count             = r_count + 1'b1;
                            end
                        end
                        default: begin
                            w_fsm_push = 1'b1;
                        end
                    endcase
                end
            end
            BS_WALK: begin
                if (w_room3) begin
                    w_issue = 1'b1;
                    if (32'(r_idx) + 32'd1 == 32'(r_count)) begin
                        n_state = BS_DRAIN;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            BS_DRAIN: begin
                // Close the query once the pipeline is empty and the result queue has room
                if (!r_s1_valid && !r_s2_valid && !w_full) begin
                    w_fsm_push = 1'b1;
                    if (r_hold_v) begin
                        w_fsm_res      = r_hold;
                        w_fsm_res.last = 1'b1;
                    end else begin
                        w_fsm_res.pair_query_index = r_qidx;
                        w_fsm_res.last             = 1'b1;
                    end
                    n_state = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_comb begin
        w_s2_match = !(r_s2_rw > i_lim) && !r_s2_thr[THR_W-1]
                     && !(i_same_set && (r_s2_rw == r_qw) && (32'(r_qidx) <= 32'(r_s2_idx)))
                     && ({1'b0, r_s2_dist} <= $unsigned(r_s2_thr));
        w_s2_res                  = '0;
        w_s2_res.pair_valid       = 1'b1;
        w_s2_res.ref_index        = RIDX_W'(r_s2_idx);
        w_s2_res.pair_query_index = r_qidx;
        w_s2_res.distance         = r_s2_dist;
        w_s2_res.status           = STAT_OK;
    end

    // A new match releases the previous one, which is then known not to be last
    assign w_s2_push  = r_s2_valid && w_s2_match && r_hold_v;
    assign o_res_push = w_fsm_push || w_s2_push;
    assign o_res      = w_s2_push ? r_hold : w_fsm_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BS_CLEAR;
            r_clr_addr <= '0;
            r_count    <= '0;
            r_idx      <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_hold_v   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_count    <= n_count;
            r_idx      <= n_idx;
            r_s1_valid <= w_issue;
            r_s2_valid <= r_s1_valid;
            if (w_latch_q) begin
                r_hold_v <= 1'b0;
            end else if (r_s2_valid && w_s2_match) begin
                r_hold_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_latch_q) begin
            r_qkey <= i_cmd.key[KEY_BITS-1:0];
            r_qw   <= i_cmd.weight;
            r_qidx <= i_cmd.qidx;
        end
        r_s1_idx  <= r_idx;
        r_s2_idx  <= r_s1_idx;
        r_s2_rw   <= r_rd_w;
        r_s2_dist <= hpm_popcnt(KEY_MAX'(r_rd_key ^ r_qkey));
        if (r_s2_valid && w_s2_match) begin
            r_hold <= w_s2_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ref_we) begin
            m_ref_key[r_count[IDX_W-1:0]] <= i_cmd.key[KEY_BITS-1:0];
            m_ref_w[r_count[IDX_W-1:0]]   <= i_cmd.weight;
        end
        r_rd_key <= m_ref_key[r_idx];
        r_rd_w   <= m_ref_w[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == BS_CLEAR) begin
            m_thr[r_clr_addr] <= '0;
        end else if (w_thr_we) begin
            m_thr[w_thr_waddr] <= i_cmd.tval;
        end
        r_s2_thr <= m_thr[w_thr_raddr];
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !o_res_push)
        else $error("result pushed into full queue");

    a_single_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_fsm_push && w_s2_push))
        else $error("walk and control pushed a result together");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= REF_DEPTH)
        else $error("reference count beyond store depth");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |-> (32'(r_idx) < 32'(r_count)))
        else $error("walk read beyond stored keys");

    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_CLEAR) |=> (r_state == BS_CLEAR || r_state == BS_IDLE))
        else $error("left table clear to a busy state");

endmodule

// File: hdl/hamming_pair_matcher.sv
// Top level of the Hamming pair matcher: ports, configuration and queues.
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid/tready         tuser req_type, tdata key and table fields
//   m_axis    out  m_axis_tvalid/tready         tdata result fields, tlast last result of a request
//   cfg       in   i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
// Threshold writes, key stores and unknown requests each return one result word and can
// follow each other every cycle while the result queue has room.
// A query within the weight limit closes with a result word once the walk has stepped
// through every stored key over the single read port of the key store.
// After reset the threshold table, (KEY_BITS+1)^2 entries (16641 by default), is cleared
// one entry a cycle; s_axis_tready stays low until the clear is done.
// A stalled m_axis holds the walk once the result queue is nearly full.
module hamming_pair_matcher #(
    parameter int KEY_BITS  = 128,
    parameter int REF_DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // key_low, key_high, query_index, thresh_row, thresh_col, thresh_value, pad
    input  logic [hpm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // req_type
    input  logic [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // pair_valid, ref_index, pair_query_index, distance, status, pad
    output logic [hpm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_index,
    input  logic [hpm_pkg::CFG_W-1:0]           i_cfg_data
);
    import hpm_pkg::*;

    localparam int CMDQ_DEPTH = 2;
    localparam int OUTQ_DEPTH = 4;
    localparam int OC_W       = $clog2(OUTQ_DEPTH + 1);

    logic               r_same_set;
    logic [CFG_W-1:0]   r_max_weight;
    logic [WGT_W-1:0]   w_lim;

    logic               w_front_push, w_cmdq_full, w_cmdq_empty, w_cmd_pop;
    t_cmd               w_front_cmd, w_cmd;
    logic [$bits(t_cmd)-1:0] w_cmdq_data;
    logic [$clog2(CMDQ_DEPTH+1)-1:0] w_cmdq_count;
    logic               w_back_ready;

    logic               w_res_push, w_outq_empty, w_outq_full;
    t_res               w_res, w_res_out;
    logic [$bits(t_res)-1:0] w_outq_data;
    logic [OC_W-1:0]    w_outq_count;

    assign o_cfg_ready = 1'b1;
    assign w_lim = (r_max_weight > WGT_W'(KEY_BITS)) ? WGT_W'(KEY_BITS) : r_max_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_same_set   <= 1'b0;
            r_max_weight <= CFG_W'(128);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SAME_SET:   r_same_set   <= i_cfg_data[0];
                CFG_MAX_WEIGHT: r_max_weight <= i_cfg_data;
                default:        r_same_set   <= r_same_set;
            endcase
        end
    end

    hpm_front #(
        .KEY_BITS (KEY_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_req      (t_req'(s_axis_tuser)),
        .i_key_low  (s_axis_tdata[63:0]),
        .i_key_high (s_axis_tdata[127:64]),
        .i_qidx     (s_axis_tdata[143:128]),
        .i_row      (s_axis_tdata[151:144]),
        .i_col      (s_axis_tdata[159:152]),
        .i_tval     (s_axis_tdata[168:160]),
        .i_lim      (w_lim),
        .i_enable   (w_back_ready),
        .i_q_full   (w_cmdq_full),
        .o_push     (w_front_push),
        .o_cmd      (w_front_cmd)
    );

    hpm_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_push),
        .i_data  (w_front_cmd),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmdq_data),
        .o_empty (w_cmdq_empty),
        .o_full  (w_cmdq_full),
        .o_count (w_cmdq_count)
    );

    assign w_cmd = t_cmd'(w_cmdq_data);

    hpm_back #(
        .KEY_BITS  (KEY_BITS),
        .REF_DEPTH (REF_DEPTH),
        .OUT_DEPTH (OUTQ_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!w_cmdq_empty),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_lim       (w_lim),
        .i_same_set  (r_same_set),
        .i_out_count (w_outq_count),
        .o_res_push  (w_res_push),
        .o_res       (w_res),
        .o_ready     (w_back_ready)
    );

    hpm_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .i_pop   (m_axis_tvalid && m_axis_tready),
        .o_data  (w_outq_data),
        .o_empty (w_outq_empty),
        .o_full  (w_outq_full),
        .o_count (w_outq_count)
    );

    assign w_res_out     = t_res'(w_outq_data);
    assign m_axis_tvalid = !w_outq_empty;
    assign m_axis_tlast  = w_res_out.last;
    assign m_axis_tdata  = {7'b0, w_res_out.status, w_res_out.distance,
                            w_res_out.pair_query_index, w_res_out.ref_index,
                            w_res_out.pair_valid};

    a_outq_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_outq_full |-> !w_res_push || (m_axis_tvalid && m_axis_tready))
        else $error("result queue overflow");

    a_cmdq_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(w_cmdq_count) <= CMDQ_DEPTH)
        else $error("request queue count out of range");

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_back_ready |-> !s_axis_tready)
        else $error("input accepted during table clear");

endmodule

// File: dv/tb_hamming_pair_matcher.sv
// Self-checking testbench for the Hamming pair matcher: directed and random requests.
`timescale 1ns / 1ps

module tb_hamming_pair_matcher;
    import hpm_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int          STORE_SLOTS = 64;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // key_low, key_high, query_index, thresh_row, thresh_col, thresh_value, pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    // req_type
    logic [1:0]             s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // pair_valid, ref_index, pair_query_index, distance, status, pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic                   i_cfg_index   = 1'b0;
    logic [CFG_W-1:0]       i_cfg_data    = '0;

    bit          calm       = 1'b0;
    int          stall_left = 0;
    int unsigned ticks      = 0;

    hamming_pair_matcher uut (.*);

    // Mirror of the key store, threshold table and registers; holds the results still due.
    class match_scoreboard;
        logic signed [8:0] thr_tab [0:128][0:128];
        logic [127:0]      ref_keys [STORE_SLOTS];
        int                ref_wgt [STORE_SLOTS];
        int unsigned       ref_cnt;
        bit                same_set;
        logic [7:0]        max_wgt;
        t_res              pairs_due [$];
        int unsigned       faults;

        function new();
            int a;
            int b;
            for (a = 0; a <= 128; a++) begin
                for (b = 0; b <= 128; b++) begin
                    thr_tab[a][b] = '0;
                end
            end
            ref_cnt  = 0;
            same_set = 1'b0;
            max_wgt  = 8'd128;
            faults   = 0;
        endfunction

        function int ones(logic [127:0] v);
            int n;
            int b;
            n = 0;
            for (b = 0; b < 128; b++) begin
                n += v[b];
            end
            return n;
        endfunction

        function string show(t_res r);
            return $sformatf("pv=%0d ref=%0d qidx=%0d dist=%0d last=%0d st=%0d", r.pair_valid,
                             r.ref_index, r.pair_query_index, r.distance, r.last, r.status);
        endfunction

        function int pending();
            return pairs_due.size();
        endfunction

        // Append one result to the tail of the due list
        function void due_add(t_res r);
            pairs_due = {pairs_due, r};
        endfunction

        function void write_reg(t_cfg_idx idx, logic [7:0] data);
            if (idx == CFG_SAME_SET) begin
                same_set = data[0];
            end else begin
                max_wgt = data;
            end
        endfunction

        function void note_request(t_req kind, logic [127:0] key, logic [15:0] qidx,
                                   logic [7:0] row, logic [7:0] col, logic signed [8:0] tval);
            int   lim;
            int   w;
            int   i;
            int   rw;
            int   t;
            int   d;
            int   hits;
            t_res r;
            t_res hit;
            lim = (max_wgt > 128) ? 128 : int'(max_wgt);
            w = ones(key);
            r = '0;
            r.last = 1'b1;
            r.status = STAT_OK;
            case (kind)
                REQ_THR: begin
                    if (row > lim || col > lim) begin
                        r.status = STAT_WEIGHT;
                    end else begin
                        thr_tab[row][col] = tval;
                    end
                    due_add(r);
                end
                REQ_STORE: begin
                    if (w > lim) begin
                        r.status = STAT_WEIGHT;
                    end else if (ref_cnt >= STORE_SLOTS) begin
                        r.status = STAT_FULL;
                    end else begin
                        ref_keys[ref_cnt] = key;
                        ref_wgt[ref_cnt] = w;
                        r.ref_index = 6'(ref_cnt);
                        ref_cnt++;
                    end
                    due_add(r);
                end
                REQ_QUERY: begin
                    r.pair_query_index = qidx;
                    if (w > lim) begin
                        r.status = STAT_WEIGHT;
                        due_add(r);
                    end else begin
                        hits = 0;
                        for (i = 0; i < int'(ref_cnt); i++) begin
                            rw = ref_wgt[i];
                            if (rw > lim) continue;
                            t = thr_tab[rw][w];
                            if (t < 0) continue;
                            // in one set, an equal-weight pair is reported from one side only
                            if (same_set && rw == w && qidx <= i) continue;
                            d = ones(key ^ ref_keys[i]);
                            if (d <= t) begin
                                hit = '0;
                                hit.pair_valid = 1'b1;
                                hit.ref_index = 6'(i);
                                hit.pair_query_index = qidx;
                                hit.distance = 8'(d);
                                hit.status = STAT_OK;
                                due_add(hit);
                                hits++;
                            end
                        end
                        if (hits == 0) begin
                            due_add(r);
                        end else begin
                            pairs_due[pairs_due.size() - 1].last = 1'b1;
                        end
                    end
                end
                default: begin
                    due_add(r);
                end
            endcase
        endfunction

        function void check_pair(t_res got);
            t_res want;
            if (pairs_due.size() == 0) begin
                faults++;
                if (faults <= 10) $display("result with nothing pending: %s", show(got));
                return;
            end
            want = pairs_due.pop_front();
            if (got !== want) begin
                faults++;
                if (faults <= 10) begin
                    $display("mismatch: expected %s, got %s", show(want), show(got));
                end
            end
        endfunction
    endclass

    match_scoreboard sb = new();

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        ticks <= ticks + 1;
        if (ticks == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: stall in random bursts until the quiet tail of the run
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 11) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_res got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.pair_valid       = m_axis_tdata[0];
            got.ref_index        = m_axis_tdata[6:1];
            got.pair_query_index = m_axis_tdata[22:7];
            got.distance         = m_axis_tdata[30:23];
            got.status           = t_status'(m_axis_tdata[32:31]);
            got.last             = m_axis_tlast;
            sb.check_pair(got);
        end
    end

    function automatic logic [127:0] sparse_key(int unsigned n);
        logic [127:0] k;
        k = '0;
        repeat (n) k[$urandom_range(0, 127)] = 1'b1;
        return k;
    endfunction

    function automatic logic [127:0] noise_key();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // Take a stored key and flip up to three bits so the new key lands close to it
    function automatic logic [127:0] near_key();
        logic [127:0] k;
        if (sb.ref_cnt == 0) return sparse_key($urandom_range(0, 9));
        k = sb.ref_keys[$urandom_range(0, sb.ref_cnt - 1)];
        repeat ($urandom_range(0, 3)) k[$urandom_range(0, 127)] ^= 1'b1;
        return k;
    endfunction

    task automatic send_req(t_req kind, logic [127:0] key, logic [15:0] qidx,
                            logic [7:0] row, logic [7:0] col, logic signed [8:0] tval);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_axis_tdata  <= {7'd0, tval, col, row, qidx, key};
        s_axis_tuser  <= kind;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(kind, key, qidx, row, col, tval);
    endtask

    task automatic random_req();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            send_req(REQ_THR, noise_key(), 16'($urandom), 8'($urandom_range(0, 9)),
                     8'($urandom_range(0, 9)), 9'($urandom_range(0, 14) - 1));
        end else if (pick < 26) begin
            send_req(REQ_THR, noise_key(), 16'($urandom), 8'($urandom), 8'($urandom),
                     9'($urandom));
        end else if (pick < 52) begin
            send_req(REQ_STORE, sparse_key($urandom_range(0, 9)), 16'($urandom),
                     8'($urandom), 8'($urandom), 9'($urandom));
        end else if (pick < 56) begin
            send_req(REQ_STORE, near_key(), 16'($urandom), 8'($urandom), 8'($urandom),
                     9'($urandom));
        end else if (pick < 60) begin
            send_req(REQ_STORE, noise_key(), 16'($urandom), 8'($urandom), 8'($urandom),
                     9'($urandom));
        end else if (pick < 92) begin
            send_req(REQ_QUERY, near_key(), 16'($urandom_range(0, 70)), 8'($urandom),
                     8'($urandom), 9'($urandom));
        end else if (pick < 96) begin
            send_req(REQ_QUERY, noise_key(), 16'($urandom), 8'($urandom), 8'($urandom),
                     9'($urandom));
        end else begin
            send_req(REQ_NONE, noise_key(), 16'($urandom), 8'($urandom), 8'($urandom),
                     9'($urandom));
        end
    endtask

    // Drop the request word and hold until every pending result has come back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic set_config(bit ss, logic [7:0] mw);
        logic [7:0] ss_word;
        ss_word = {7'($urandom), ss};
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_SAME_SET;
        i_cfg_data  <= ss_word;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(CFG_SAME_SET, ss_word);
        i_cfg_index <= CFG_MAX_WEIGHT;
        i_cfg_data  <= mw;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(CFG_MAX_WEIGHT, mw);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(bit ss, logic [7:0] mw, int unsigned n);
        settle();
        set_config(ss, mw);
        repeat (n) random_req();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty store, ignored request, table writes off the edge and at the corners
        send_req(REQ_QUERY, '0, 16'd0, 8'd0, 8'd0, 9'sd0);
        send_req(REQ_NONE, {128{1'b1}}, 16'hFFFF, 8'hFF, 8'hFF, 9'h1FF);
        send_req(REQ_THR, '0, 16'd0, 8'd129, 8'd0, 9'sd5);
        send_req(REQ_THR, '0, 16'd0, 8'd0, 8'd255, 9'sd5);
        send_req(REQ_THR, '0, 16'd0, 8'd0, 8'd128, 9'sd128);
        send_req(REQ_THR, '0, 16'd0, 8'd128, 8'd128, 9'sd128);
        // most negative entry: the pair is disabled
        send_req(REQ_THR, '0, 16'd0, 8'd128, 8'd0, 9'h100);
        send_req(REQ_STORE, '0, 16'd0, 8'd0, 8'd0, 9'sd0);
        send_req(REQ_STORE, {128{1'b1}}, 16'd0, 8'd0, 8'd0, 9'sd0);
        send_req(REQ_QUERY, '0, 16'd0, 8'd0, 8'd0, 9'sd0);
        send_req(REQ_QUERY, {128{1'b1}}, 16'hFFFF, 8'd0, 8'd0, 9'sd0);
        send_req(REQ_THR, '0, 16'd0, 8'd0, 8'd0, -9'sd1);
        send_req(REQ_QUERY, '0, 16'd3, 8'd0, 8'd0, 9'sd0);
        send_req(REQ_THR, '0, 16'd0, 8'd0, 8'd0, 9'sd0);
        send_req(REQ_STORE, {1'b1, 126'd0, 1'b1}, 16'd0, 8'd0, 8'd0, 9'sd0);

        // one set, nothing above weight zero accepted
        run_phase(1'b1, 8'd0, 0);
        send_req(REQ_STORE, '0, 16'd0, 8'd0, 8'd0, 9'sd0);
        send_req(REQ_STORE, 128'(1) << 64, 16'd0, 8'd0, 8'd0, 9'sd0);
        send_req(REQ_QUERY, '0, 16'd0, 8'd0, 8'd0, 9'sd0);
        send_req(REQ_QUERY, '0, 16'd3, 8'd0, 8'd0, 9'sd0);
        send_req(REQ_QUERY, '0, 16'd4, 8'd0, 8'd0, 9'sd0);
        send_req(REQ_QUERY, 128'(1) << 5, 16'd9, 8'd0, 8'd0, 9'sd0);
        send_req(REQ_THR, '0, 16'd0, 8'd1, 8'd0, 9'sd3);
        send_req(REQ_THR, '0, 16'd0, 8'd0, 8'd0, 9'sd2);

        run_phase(1'b0, 8'd9, 20);
        run_phase(1'b1, 8'd6, 20);
        run_phase(1'b0, 8'd255, 20);
        run_phase(1'b1, 8'd128, 20);

        // fill the store, then knock on it a few more times
        run_phase(1'b0, 8'd255, 0);
        while (sb.ref_cnt < STORE_SLOTS) begin
            send_req(REQ_STORE, sparse_key($urandom_range(0, 9)), 16'($urandom), 8'($urandom),
                     8'($urandom), 9'($urandom));
        end
        repeat (3) begin
            send_req(REQ_STORE, sparse_key($urandom_range(0, 9)), 16'($urandom), 8'($urandom),
                     8'($urandom), 9'($urandom));
        end
        repeat (15) random_req();

        calm <= 1'b1;
        run_phase(1'b1, 8'd9, 20);
        settle();
        repeat (100) @(posedge i_clk);

        if (sb.faults == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: hamming_pair_matcher.f
hdl/hpm_pkg.sv
hdl/hpm_fifo.sv
hdl/hpm_front.sv
hdl/hpm_back.sv
hdl/hamming_pair_matcher.sv
dv/tb_hamming_pair_matcher.sv
